### src/btpm_pkg.sv
package btpm_pkg;

    localparam int NODE_COUNT = 65536;
    localparam int VALUE_BITS = 32;
    localparam int IDX_W      = $clog2(NODE_COUNT);
    localparam int FREE_W     = IDX_W + 1;
    localparam int LINK_W     = 2 * IDX_W;
    localparam int PAY_W      = VALUE_BITS + 1;

    localparam logic [7:0] V4_BITS = 8'd32;
    localparam logic [7:0] V6_BITS = 8'd128;

    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_KEPT    = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_TOOLONG = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic        family;
        logic [63:0] addr_hi;
        logic [63:0] addr_lo;
        logic [7:0]  pfx_len;
        logic [31:0] value;
    } t_cmd_in;

    typedef struct packed {
        logic        hit;
        logic [31:0] match_value;
        logic [1:0]  status;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LK_WALK,
        S_IN_WALK,
        S_IN_CHECK,
        S_IN_ALLOC
    } t_state;

endpackage

### src/btpm_ram.sv
module btpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/binary_trie_prefix_match.sv
// Lookup walks from the family's root down the address bits until a null node or the full address
// length; insert runs a path walk, a pool check, the allocation of each new node and a final store.
// Clear, unused commands and over-long prefixes answer straight from idle. One command at a time.
// Throughput is set by the single read port of the node memories, one trie level per cycle.
// Synchronous active-low reset empties both tries; node memories need no clearing pass.
// The result strobe lasts one cycle and the receiver cannot stall it.
module binary_trie_prefix_match (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  btpm_pkg::t_cmd_in i_cmd,
    output logic              busy,
    output logic              o_strobe,
    output btpm_pkg::t_result o_result
);
    import btpm_pkg::*;

    t_state r_state, n_state;
    logic [IDX_W-1:0]      r_cur, n_cur;
    logic [7:0]            r_depth, n_depth;
    logic [7:0]            r_plen, n_plen;
    logic [127:0]          r_addr, n_addr;
    logic                  r_fam, n_fam;
    logic [VALUE_BITS-1:0] r_value, n_value;
    logic [LINK_W-1:0]     r_links, n_links;
    logic                  r_pvalid, n_pvalid;
    logic [IDX_W-1:0]      r_root [2];
    logic [IDX_W-1:0]      n_root [2];
    logic [FREE_W-1:0]     r_next_free, n_next_free;
    logic                  r_hit, n_hit;
    logic [VALUE_BITS-1:0] r_mval, n_mval;
    logic [1:0]            r_status, n_status;
    logic                  r_strobe, n_strobe;

    logic [IDX_W-1:0]  raddr;
    logic [LINK_W-1:0] rd_links;
    logic [PAY_W-1:0]  rd_pay;
    logic              link_we, pay_we;
    logic [IDX_W-1:0]  link_waddr, pay_waddr;
    logic [LINK_W-1:0] link_wdata;
    logic [PAY_W-1:0]  pay_wdata;

    logic [IDX_W-1:0]  child;
    logic [7:0]        alen, in_alen;
    logic [8:0]        need;
    logic [FREE_W:0]   need_end;
    logic [IDX_W-1:0]  nf_idx;

    btpm_ram #(.WIDTH(LINK_W), .DEPTH(NODE_COUNT)) u_links (
        .i_clk  (i_clk),
        .i_we   (link_we),
        .i_waddr(link_waddr),
        .i_wdata(link_wdata),
        .i_raddr(raddr),
        .o_rdata(rd_links)
    );

    btpm_ram #(.WIDTH(PAY_W), .DEPTH(NODE_COUNT)) u_payload (
        .i_clk  (i_clk),
        .i_we   (pay_we),
        .i_waddr(pay_waddr),
        .i_wdata(pay_wdata),
        .i_raddr(raddr),
        .o_rdata(rd_pay)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_root[0]   <= '0;
            r_root[1]   <= '0;
            r_next_free <= FREE_W'(1);
            r_strobe    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_root[0]   <= n_root[0];
            r_root[1]   <= n_root[1];
            r_next_free <= n_next_free;
            r_strobe    <= n_strobe;
        end
        r_cur    <= n_cur;
        r_depth  <= n_depth;
        r_plen   <= n_plen;
        r_addr   <= n_addr;
        r_fam    <= n_fam;
        r_value  <= n_value;
        r_links  <= n_links;
        r_pvalid <= n_pvalid;
        r_hit    <= n_hit;
        r_mval   <= n_mval;
        r_status <= n_status;
    end

    // The child on the current address bit, taken straight from the read data.
    assign child    = r_addr[127] ? rd_links[IDX_W +: IDX_W] : rd_links[0 +: IDX_W];
    assign alen     = r_fam ? V6_BITS : V4_BITS;
    assign in_alen  = i_cmd.family ? V6_BITS : V4_BITS;
    assign need     = (r_cur == '0) ? ({1'b0, r_plen} + 9'd1) : ({1'b0, r_plen} - {1'b0, r_depth});
    assign need_end = {1'b0, r_next_free} + (FREE_W + 1)'(need);
    assign nf_idx   = r_next_free[IDX_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_cur       = r_cur;
        n_depth     = r_depth;
        n_plen      = r_plen;
        n_addr      = r_addr;
        n_fam       = r_fam;
        n_value     = r_value;
        n_links     = r_links;
        n_pvalid    = r_pvalid;
        n_root[0]   = r_root[0];
        n_root[1]   = r_root[1];
        n_next_free = r_next_free;
        n_hit       = r_hit;
        n_mval      = r_mval;
        n_status    = r_status;
        n_strobe    = 1'b0;
        raddr       = r_cur;
        link_we     = 1'b0;
        link_waddr  = r_cur;
        link_wdata  = r_links;
        pay_we      = 1'b0;
        pay_waddr   = r_cur;
        pay_wdata   = '0;

        unique case (r_state)
            S_IDLE: begin
                raddr = r_root[i_cmd.family];
                if (start) begin
                    n_cur    = r_root[i_cmd.family];
                    n_depth  = '0;
                    n_plen   = i_cmd.pfx_len;
                    n_addr   = {i_cmd.addr_hi, i_cmd.addr_lo};
                    n_fam    = i_cmd.family;
                    n_value  = i_cmd.value[VALUE_BITS-1:0];
                    n_hit    = 1'b0;
                    n_mval   = '0;
                    n_status = ST_OK;
                    unique case (i_cmd.cmd)
                        CMD_LOOKUP: n_state = S_LK_WALK;
                        CMD_INSERT: begin
                            if (i_cmd.pfx_len > in_alen) begin
                                n_status = ST_TOOLONG;
                                n_strobe = 1'b1;
                            end else begin
                                n_state = S_IN_WALK;
                            end
                        end
                        CMD_CLEAR: begin
                            n_root[0]   = '0;
                            n_root[1]   = '0;
                            n_next_free = FREE_W'(1);
                            n_strobe    = 1'b1;
                        end
                        default: n_strobe = 1'b1;
                    endcase
                end
            end

            S_LK_WALK: begin
                if (r_cur == '0) begin
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    if (rd_pay[VALUE_BITS]) begin
                        n_hit  = 1'b1;
                        n_mval = rd_pay[VALUE_BITS-1:0];
                    end
                    if (r_depth >= alen) begin
                        n_strobe = 1'b1;
                        n_state  = S_IDLE;
                    end else begin
                        raddr   = child;
                        n_cur   = child;
                        n_depth = r_depth + 8'd1;
                        n_addr  = {r_addr[126:0], 1'b0};
                    end
                end
            end

            S_IN_WALK: begin
                if (r_cur == '0) begin
                    n_state = S_IN_CHECK;
                end else begin
                    n_links  = rd_links;
                    n_pvalid = rd_pay[VALUE_BITS];
                    if (r_depth < r_plen && child != '0) begin
                        raddr   = child;
                        n_cur   = child;
                        n_depth = r_depth + 8'd1;
                        n_addr  = {r_addr[126:0], 1'b0};
                    end else begin
                        n_state = S_IN_CHECK;
                    end
                end
            end

            S_IN_CHECK: begin
                if (need_end > (FREE_W + 1)'(NODE_COUNT)) begin
                    n_status = ST_FULL;
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    if (r_cur == '0) begin
                        pay_we        = 1'b1;
                        pay_waddr     = nf_idx;
                        pay_wdata     = '0;
                        n_root[r_fam] = nf_idx;
                        n_cur         = nf_idx;
                        n_links       = '0;
                        n_pvalid      = 1'b0;
                        n_next_free   = r_next_free + FREE_W'(1);
                    end
                    n_state = S_IN_ALLOC;
                end
            end

            S_IN_ALLOC: begin
                link_we    = 1'b1;
                link_waddr = r_cur;
                if (r_depth < r_plen) begin
                    // Hook a fresh node under the current one, keeping its other child.
                    link_wdata = r_links;
                    if (r_addr[127]) begin
                        link_wdata[IDX_W +: IDX_W] = nf_idx;
                    end else begin
                        link_wdata[0 +: IDX_W] = nf_idx;
                    end
                    pay_we      = 1'b1;
                    pay_waddr   = nf_idx;
                    pay_wdata   = '0;
                    n_cur       = nf_idx;
                    n_links     = '0;
                    n_pvalid    = 1'b0;
                    n_next_free = r_next_free + FREE_W'(1);
                    n_depth     = r_depth + 8'd1;
                    n_addr      = {r_addr[126:0], 1'b0};
                end else begin
                    link_wdata = r_links;
                    if (r_pvalid) begin
                        n_status = ST_KEPT;
                    end else begin
                        pay_we    = 1'b1;
                        pay_waddr = r_cur;
                        pay_wdata = {1'b1, r_value};
                    end
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    assign busy                 = (r_state != S_IDLE);
    assign o_strobe             = r_strobe;
    assign o_result.hit         = r_hit;
    assign o_result.match_value = 32'(r_mval);
    assign o_result.status      = r_status;

    a_pool_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_free <= FREE_W'(NODE_COUNT))
        else $error("allocator ran past the node pool");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> !busy)
        else $error("result beat while still busy");

    a_hit_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_hit) |-> (r_status == ST_OK))
        else $error("hit reported with a nonzero status");

    a_alloc_writes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IN_ALLOC) |-> link_we)
        else $error("allocation step without a link write");

endmodule
